@@ sv/brta_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and helpers for the boot region table allocator.
package brta_pkg;

   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   // Operation codes carried in req_tuser
   typedef enum logic [1:0] {
      MODE_ADD_MEM = 2'd0,
      MODE_RESERVE = 2'd1,
      MODE_FREE    = 2'd2,
      MODE_ALLOC   = 2'd3
   } mode_type;

   // Result codes carried in rsp_tuser
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_NO_FIT    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_COUNT,
      S_UNION,
      S_FREE,
      S_WALK,
      S_RESTORE,
      S_DONE
   } fsm_type;

   // One region, kept as [base, lim)
   typedef struct packed {
      logic [63:0] base;
      logic [63:0] lim;
   } rgn_type;

   // Per-cycle command to a region chain
   typedef struct packed {
      logic    pop;
      logic    push;
      rgn_type pdata;
   } chain_ctl_type;

   // End of a range, saturated at the top of the address space
   function automatic logic [63:0] range_end(input logic [63:0] b, input logic [63:0] s);
      logic [64:0] sum;
      sum = {1'b0, b} + {1'b0, s};
      return sum[64] ? ALL_ONES : sum[63:0];
   endfunction

endpackage

@@ sv/brta_cell.sv @@
`timescale 1ns / 1ps
// One storage cell of a region chain: holds a region, takes its neighbor's on a pop.
module brta_cell #(
   parameter int IDX = 0,
   parameter int CW  = 8
) (
   input  logic                    clock,
   input  brta_pkg::chain_ctl_type ctl,
   input  logic [CW-1:0]           cnt,
   input  brta_pkg::rgn_type       nxt,
   output brta_pkg::rgn_type       q
);

   brta_pkg::rgn_type q_ff;
   brta_pkg::rgn_type q_in;

   // Shift toward the head on pop; the push lands just behind the last valid entry
   always_comb begin
      q_in = q_ff;
      if (ctl.pop) begin
         if (ctl.push && (cnt == CW'(IDX + 1))) begin
            q_in = ctl.pdata;
         end else begin
            q_in = nxt;
         end
      end else if (ctl.push && (cnt == CW'(IDX))) begin
         q_in = ctl.pdata;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign q = q_ff;

endmodule

@@ sv/brta_chain.sv @@
`timescale 1ns / 1ps
// Row of region cells forming an ordered queue: read at the head, appended at the tail.
module brta_chain #(
   parameter int DEPTH = 128
) (
   input  logic                         clock,
   input  logic                         reset,
   input  brta_pkg::chain_ctl_type      ctl,
   output brta_pkg::rgn_type            head,
   output logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int CW = $clog2(DEPTH + 1);

   brta_pkg::rgn_type cell_q [DEPTH];
   logic [CW-1:0]     count_ff;
   logic [CW-1:0]     count_in;

   // Cells, each fed by its upper neighbor; the last cell feeds back on itself
   for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
      brta_pkg::rgn_type nxt;
      if (gi == DEPTH - 1) begin : g_last
         assign nxt = cell_q[gi];
      end else begin : g_mid
         assign nxt = cell_q[gi + 1];
      end
      brta_cell #(.IDX(gi), .CW(CW)) u_cell (
         .clock (clock),
         .ctl   (ctl),
         .cnt   (count_ff),
         .nxt   (nxt),
         .q     (cell_q[gi])
      );
   end

   // Occupancy
   assign count_in = count_ff + CW'(ctl.push) - CW'(ctl.pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign head  = cell_q[0];
   assign count = count_ff;

endmodule

@@ sv/boot_region_table_allocator_core.sv @@
`timescale 1ns / 1ps
// Top level of the boot region table allocator: sequencer and the two region chains.
//
// Usage:
//   req channel carries one operation per transaction: add memory, reserve, free a
//   reserved range or allocate (first fit over memory minus reserved, aligned up).
//   rsp channel returns one result per operation: status, allocation address, base of
//   the lowest memory region and both region counts as they stand after the operation.
//   Both tables live in chains of cells that are walked from the head, every entry
//   going back to the tail. Add and reserve make one counting pass and one merging
//   pass over their table; free makes one pass over the reserved table; allocate
//   walks memory minus reserved, restores the order of both tables, then reserves
//   a hit of nonzero size with a counting and a merging pass over the reserved table.
//   One operation is in flight at a time; req_tready is high only while idle.
//   A finished result waits in the output register while the next request is taken;
//   if the receiver stalls, the block finishes its next operation and holds it until
//   the output register frees up.
//   Reset empties both tables and drops any pending result; no clearing pass is needed.
module boot_region_table_allocator_core #(
   parameter int MEM_REGIONS = 128,
   parameter int RES_REGIONS = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // base[63:0], size[127:64], min_address[191:128], align_log2[197:192], zero pad
   input  logic [199:0] req_tdata,
   // mode[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // alloc_address[63:0], ram_base[127:64], memory_count[135:128],
   // reserved_count[143:136]
   output logic [143:0] rsp_tdata,
   // status[1:0]
   output logic [1:0]   rsp_tuser
);

   localparam int MCW = $clog2(MEM_REGIONS + 1);
   localparam int RCW = $clog2(RES_REGIONS + 1);
   localparam int TCW = (MCW > RCW) ? MCW : RCW;
   localparam int NW  = TCW + 1;

   // Chains
   brta_pkg::chain_ctl_type mem_ctl, res_ctl, t_ctl;
   brta_pkg::rgn_type       mem_head, res_head, t_head;
   logic [MCW-1:0]          mem_cnt;
   logic [RCW-1:0]          res_cnt;
   logic [TCW-1:0]          t_cnt, t_cap;

   brta_chain #(.DEPTH(MEM_REGIONS)) u_mem (
      .clock (clock),
      .reset (reset),
      .ctl   (mem_ctl),
      .head  (mem_head),
      .count (mem_cnt)
   );

   brta_chain #(.DEPTH(RES_REGIONS)) u_res (
      .clock (clock),
      .reset (reset),
      .ctl   (res_ctl),
      .head  (res_head),
      .count (res_cnt)
   );

   // Sequencer state
   brta_pkg::fsm_type    state_ff, state_in;
   logic                 tsel_ff, tsel_in;
   logic                 alloc_ff, alloc_in;
   logic [63:0]          b_ff, b_in, e_ff, e_in, size_ff, size_in;
   logic [63:0]          minad_ff, minad_in, mask_ff, mask_in;
   logic [63:0]          c_ff, c_in;
   logic                 stop_ff, stop_in;
   logic [NW-1:0]        need_ff, need_in;
   logic [TCW-1:0]       tk_ff, tk_in, tn_ff, tn_in;
   logic                 rused_ff, rused_in, pv_ff, pv_in;
   brta_pkg::rgn_type    p_ff, p_in;
   logic                 found_ff, found_in, second_ff, second_in, ld_ff, ld_in;
   logic [MCW-1:0]       mk_ff, mk_in;
   logic [RCW-1:0]       rk_ff, rk_in;
   logic [63:0]          hit_ff, hit_in;
   logic                 hitv_ff, hitv_in;
   brta_pkg::status_type status_ff, status_in;
   logic [63:0]          addr_ff, addr_in;

   // Output register
   logic                 rsp_valid_ff, rsp_valid_in;
   brta_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [63:0]          rsp_addr_ff, rsp_addr_in, rsp_ram_ff, rsp_ram_in;
   logic [7:0]           rsp_mcnt_ff, rsp_mcnt_in, rsp_rcnt_ff, rsp_rcnt_in;

   // Request fields
   logic [63:0]          req_base, req_size, req_minad, req_end;
   logic [5:0]           req_lg;
   brta_pkg::mode_type   req_mode;
   logic                 req_empty;

   assign req_base  = req_tdata[63:0];
   assign req_size  = req_tdata[127:64];
   assign req_minad = req_tdata[191:128];
   assign req_lg    = req_tdata[197:192];
   assign req_mode  = brta_pkg::mode_type'(req_tuser);
   assign req_end   = brta_pkg::range_end(req_base, req_size);
   assign req_empty = (req_size == 64'd0) || (req_end <= req_base);

   // Selected table for add and free passes
   assign t_head = tsel_ff ? res_head : mem_head;
   assign t_cnt  = tsel_ff ? TCW'(res_cnt) : TCW'(mem_cnt);
   assign t_cap  = tsel_ff ? TCW'(RES_REGIONS) : TCW'(MEM_REGIONS);

   // Free-range fit test at the walk cursor
   logic [63:0] piece_end, fit_addr;
   logic [64:0] fit_up, fit_top;
   logic        fit_ok;

   always_comb begin
      fit_up   = {1'b0, c_ff} + {1'b0, mask_ff};
      fit_addr = fit_up[63:0] & ~mask_ff;
      fit_top  = {1'b0, fit_addr} + {1'b0, size_ff};
      fit_ok   = (c_ff >= minad_ff) && !fit_up[64] && !fit_top[64]
                 && (fit_top[63:0] <= piece_end);
   end

   assign req_tready = (state_ff == brta_pkg::S_IDLE);

   // Next state and chain commands
   always_comb begin
      logic [NW-1:0]     need_fin;
      logic              xv, take_r, res_live;
      brta_pkg::rgn_type z;

      state_in  = state_ff;
      tsel_in   = tsel_ff;
      alloc_in  = alloc_ff;
      b_in      = b_ff;
      e_in      = e_ff;
      size_in   = size_ff;
      minad_in  = minad_ff;
      mask_in   = mask_ff;
      c_in      = c_ff;
      stop_in   = stop_ff;
      need_in   = need_ff;
      tk_in     = tk_ff;
      tn_in     = tn_ff;
      rused_in  = rused_ff;
      pv_in     = pv_ff;
      p_in      = p_ff;
      found_in  = found_ff;
      second_in = second_ff;
      ld_in     = ld_ff;
      mk_in     = mk_ff;
      rk_in     = rk_ff;
      hit_in    = hit_ff;
      hitv_in   = hitv_ff;
      status_in = status_ff;
      addr_in   = addr_ff;
      mem_ctl   = '0;
      res_ctl   = '0;
      t_ctl     = '0;
      piece_end = mem_head.lim;
      need_fin  = need_ff + NW'(e_ff > c_ff);
      xv        = (tk_ff < tn_ff);
      take_r    = 1'b0;
      res_live  = (rk_ff < res_cnt) && (res_head.base < mem_head.lim);
      z         = t_head;

      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_ram_in    = rsp_ram_ff;
      rsp_mcnt_in   = rsp_mcnt_ff;
      rsp_rcnt_in   = rsp_rcnt_ff;

      unique case (state_ff)
         brta_pkg::S_IDLE: begin
            if (req_tvalid) begin
               b_in      = req_base;
               e_in      = req_end;
               size_in   = req_size;
               minad_in  = req_minad;
               mask_in   = (64'd1 << req_lg) - 64'd1;
               status_in = brta_pkg::ST_OK;
               addr_in   = '0;
               alloc_in  = 1'b0;
               c_in      = req_base;
               stop_in   = 1'b0;
               need_in   = '0;
               tk_in     = '0;
               unique case (req_mode)
                  brta_pkg::MODE_ADD_MEM,
                  brta_pkg::MODE_RESERVE: begin
                     tsel_in  = (req_mode == brta_pkg::MODE_RESERVE);
                     state_in = req_empty ? brta_pkg::S_DONE : brta_pkg::S_COUNT;
                  end
                  brta_pkg::MODE_FREE: begin
                     tsel_in   = 1'b1;
                     found_in  = 1'b0;
                     second_in = 1'b0;
                     tn_in     = TCW'(res_cnt);
                     state_in  = req_empty ? brta_pkg::S_DONE : brta_pkg::S_FREE;
                  end
                  default: begin
                     ld_in    = 1'b1;
                     mk_in    = '0;
                     rk_in    = '0;
                     hitv_in  = 1'b0;
                     state_in = brta_pkg::S_WALK;
                  end
               endcase
            end
         end

         // Counting pass: gaps the new range would fill
         brta_pkg::S_COUNT: begin
            if (tk_ff == t_cnt) begin
               if (need_fin > NW'(t_cap - t_cnt)) begin
                  status_in = brta_pkg::ST_OVERFLOW;
                  addr_in   = '0;
                  state_in  = brta_pkg::S_DONE;
               end else begin
                  rused_in = 1'b0;
                  pv_in    = 1'b0;
                  tk_in    = '0;
                  tn_in    = t_cnt;
                  state_in = brta_pkg::S_UNION;
               end
            end else begin
               t_ctl.pop   = 1'b1;
               t_ctl.push  = 1'b1;
               t_ctl.pdata = t_head;
               tk_in       = tk_ff + TCW'(1);
               if (!stop_ff) begin
                  if (e_ff <= t_head.base) begin
                     stop_in = 1'b1;
                  end else if (c_ff < t_head.lim) begin
                     if (c_ff < t_head.base) begin
                        need_in = need_ff + NW'(1);
                     end
                     c_in = (e_ff < t_head.lim) ? e_ff : t_head.lim;
                  end
               end
            end
         end

         // Merging pass: table entries and the new range, touching ones joined
         brta_pkg::S_UNION: begin
            if (!xv && rused_ff) begin
               t_ctl.push  = pv_ff;
               t_ctl.pdata = p_ff;
               if (alloc_ff) begin
                  addr_in = hit_ff;
               end
               state_in = brta_pkg::S_DONE;
            end else begin
               take_r = !rused_ff && (!xv || (b_ff <= t_head.base));
               if (take_r) begin
                  z.base   = b_ff;
                  z.lim    = e_ff;
                  rused_in = 1'b1;
               end else begin
                  z         = t_head;
                  t_ctl.pop = 1'b1;
                  tk_in     = tk_ff + TCW'(1);
               end
               if (!pv_ff) begin
                  p_in  = z;
                  pv_in = 1'b1;
               end else if (z.base <= p_ff.lim) begin
                  p_in.lim = (z.lim > p_ff.lim) ? z.lim : p_ff.lim;
               end else begin
                  t_ctl.push  = 1'b1;
                  t_ctl.pdata = p_ff;
                  p_in        = z;
               end
            end
         end

         // Free pass: remove, trim or split the first reserved region holding the range
         brta_pkg::S_FREE: begin
            if (!xv) begin
               if (!found_ff) begin
                  status_in = brta_pkg::ST_NOT_FOUND;
               end
               state_in = brta_pkg::S_DONE;
            end else if (second_ff) begin
               t_ctl.pop        = 1'b1;
               t_ctl.push       = 1'b1;
               t_ctl.pdata.base = e_ff;
               t_ctl.pdata.lim  = t_head.lim;
               tk_in            = tk_ff + TCW'(1);
               second_in        = 1'b0;
            end else if (found_ff || (b_ff < t_head.base) || (e_ff > t_head.lim)) begin
               t_ctl.pop   = 1'b1;
               t_ctl.push  = 1'b1;
               t_ctl.pdata = t_head;
               tk_in       = tk_ff + TCW'(1);
            end else begin
               found_in = 1'b1;
               if ((b_ff == t_head.base) && (e_ff == t_head.lim)) begin
                  t_ctl.pop = 1'b1;
                  tk_in     = tk_ff + TCW'(1);
               end else if (b_ff == t_head.base) begin
                  t_ctl.pop        = 1'b1;
                  t_ctl.push       = 1'b1;
                  t_ctl.pdata.base = e_ff;
                  t_ctl.pdata.lim  = t_head.lim;
                  tk_in            = tk_ff + TCW'(1);
               end else if (e_ff == t_head.lim) begin
                  t_ctl.pop        = 1'b1;
                  t_ctl.push       = 1'b1;
                  t_ctl.pdata.base = t_head.base;
                  t_ctl.pdata.lim  = b_ff;
                  tk_in            = tk_ff + TCW'(1);
               end else if (tn_ff >= t_cap) begin
                  // split would overflow: keep the region as it is
                  t_ctl.pop   = 1'b1;
                  t_ctl.push  = 1'b1;
                  t_ctl.pdata = t_head;
                  tk_in       = tk_ff + TCW'(1);
                  status_in   = brta_pkg::ST_OVERFLOW;
               end else begin
                  // lower piece now, upper piece next cycle
                  t_ctl.push       = 1'b1;
                  t_ctl.pdata.base = t_head.base;
                  t_ctl.pdata.lim  = b_ff;
                  second_in        = 1'b1;
               end
            end
         end

         // Allocation walk: memory minus reserved, one step per cycle
         brta_pkg::S_WALK: begin
            if (mk_ff == mem_cnt) begin
               status_in = brta_pkg::ST_NO_FIT;
               state_in  = brta_pkg::S_RESTORE;
            end else if (ld_ff) begin
               c_in  = mem_head.base;
               ld_in = 1'b0;
            end else if (c_ff >= mem_head.lim) begin
               mem_ctl.pop   = 1'b1;
               mem_ctl.push  = 1'b1;
               mem_ctl.pdata = mem_head;
               mk_in         = mk_ff + MCW'(1);
               ld_in         = 1'b1;
            end else if (res_live && (res_head.lim <= c_ff)) begin
               res_ctl.pop   = 1'b1;
               res_ctl.push  = 1'b1;
               res_ctl.pdata = res_head;
               rk_in         = rk_ff + RCW'(1);
            end else if (res_live && (res_head.base <= c_ff)) begin
               c_in = res_head.lim;
            end else begin
               piece_end = res_live ? res_head.base : mem_head.lim;
               if (fit_ok) begin
                  hit_in   = fit_addr;
                  hitv_in  = 1'b1;
                  state_in = brta_pkg::S_RESTORE;
               end else begin
                  c_in = res_live ? res_head.lim : mem_head.lim;
               end
            end
         end

         // Finish the rotation of both tables, then reserve the hit if there is one of nonzero size
         brta_pkg::S_RESTORE: begin
            if (mk_ff != mem_cnt) begin
               mem_ctl.pop   = 1'b1;
               mem_ctl.push  = 1'b1;
               mem_ctl.pdata = mem_head;
               mk_in         = mk_ff + MCW'(1);
            end
            if (rk_ff != res_cnt) begin
               res_ctl.pop   = 1'b1;
               res_ctl.push  = 1'b1;
               res_ctl.pdata = res_head;
               rk_in         = rk_ff + RCW'(1);
            end
            if ((mk_ff == mem_cnt) && (rk_ff == res_cnt)) begin
               if (!hitv_ff) begin
                  state_in = brta_pkg::S_DONE;
               end else if (size_ff == 64'd0) begin
                  addr_in  = hit_ff;
                  state_in = brta_pkg::S_DONE;
               end else begin
                  tsel_in  = 1'b1;
                  alloc_in = 1'b1;
                  b_in     = hit_ff;
                  e_in     = hit_ff + size_ff;
                  c_in     = hit_ff;
                  stop_in  = 1'b0;
                  need_in  = '0;
                  tk_in    = '0;
                  state_in = brta_pkg::S_COUNT;
               end
            end
         end

         // Hand the result to the output register once it is free
         brta_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_addr_in   = (status_ff == brta_pkg::ST_OK) ? addr_ff : 64'd0;
               rsp_ram_in    = (mem_cnt != '0) ? mem_head.base : 64'd0;
               rsp_mcnt_in   = 8'(mem_cnt);
               rsp_rcnt_in   = 8'(res_cnt);
               state_in      = brta_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = brta_pkg::S_IDLE;
         end
      endcase

      // Route the selected-table command
      if ((state_ff == brta_pkg::S_COUNT) || (state_ff == brta_pkg::S_UNION)
          || (state_ff == brta_pkg::S_FREE)) begin
         if (tsel_ff) begin
            res_ctl = t_ctl;
         end else begin
            mem_ctl = t_ctl;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= brta_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and result registers
   always_ff @(posedge clock) begin
      tsel_ff       <= tsel_in;
      alloc_ff      <= alloc_in;
      b_ff          <= b_in;
      e_ff          <= e_in;
      size_ff       <= size_in;
      minad_ff      <= minad_in;
      mask_ff       <= mask_in;
      c_ff          <= c_in;
      stop_ff       <= stop_in;
      need_ff       <= need_in;
      tk_ff         <= tk_in;
      tn_ff         <= tn_in;
      rused_ff      <= rused_in;
      pv_ff         <= pv_in;
      p_ff          <= p_in;
      found_ff      <= found_in;
      second_ff     <= second_in;
      ld_ff         <= ld_in;
      mk_ff         <= mk_in;
      rk_ff         <= rk_in;
      hit_ff        <= hit_in;
      hitv_ff       <= hitv_in;
      status_ff     <= status_in;
      addr_ff       <= addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_ram_ff    <= rsp_ram_in;
      rsp_mcnt_ff   <= rsp_mcnt_in;
      rsp_rcnt_ff   <= rsp_rcnt_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {rsp_rcnt_ff, rsp_mcnt_ff, rsp_ram_ff, rsp_addr_ff};

endmodule

@@ sv/brta_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the boot region table allocator, bound to the top level.
module brta_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [199:0] req_tdata,
   input logic [1:0]   req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [143:0] rsp_tdata,
   input logic [1:0]   rsp_tuser
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // Failed operations report no address
   a_fail_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != brta_pkg::ST_OK) |-> (rsp_tdata[63:0] == 64'd0))
      else $error("nonzero address on failure");

   // One operation at a time: accepting a transaction closes the input
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input open right after accepting a transaction");

   // Reset drops any pending result
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind boot_region_table_allocator_core brta_checker u_brta_checker (.*);

@@ sim/boot_region_table_allocator_checker.sv @@
`timescale 1ns / 1ps
// Checker for the boot region table allocator: region table predictor and result compare.
module boot_region_table_allocator_checker #(
   parameter int MEM_REGIONS = 128,
   parameter int RES_REGIONS = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [199:0] req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [143:0] rsp_tdata,
   input  logic [1:0]   rsp_tuser,
   output int           errors,
   output int           pending
);

   localparam int MEM_TBL = 0;
   localparam int RSV_TBL = 1;
   localparam int DEPTH   = (MEM_REGIONS > RES_REGIONS) ? MEM_REGIONS : RES_REGIONS;

   typedef struct {
      brta_pkg::status_type status;
      logic [63:0]          alloc_address;
      logic [63:0]          ram_base;
      logic [7:0]           memory_count;
      logic [7:0]           reserved_count;
   } outcome_type;

   // Shadow copy of both region tables
   logic [63:0] rgn_base [2][DEPTH];
   logic [63:0] rgn_size [2][DEPTH];
   int          rgn_count[2];
   outcome_type outcome_q[$];

   function automatic int capacity(int t);
      return (t == MEM_TBL) ? MEM_REGIONS : RES_REGIONS;
   endfunction

   function automatic logic [63:0] sat_end(logic [63:0] b, logic [63:0] s);
      logic [64:0] sum;
      sum = {1'b0, b} + {1'b0, s};
      return sum[64] ? brta_pkg::ALL_ONES : sum[63:0];
   endfunction

   function automatic void rgn_insert(int t, int at, logic [63:0] b, logic [63:0] s);
      for (int j = rgn_count[t] - 1; j >= at; j--) begin
         rgn_base[t][j + 1] = rgn_base[t][j];
         rgn_size[t][j + 1] = rgn_size[t][j];
      end
      rgn_base[t][at] = b;
      rgn_size[t][at] = s;
      rgn_count[t]++;
   endfunction

   function automatic void rgn_delete(int t, int at);
      for (int j = at; j < rgn_count[t] - 1; j++) begin
         rgn_base[t][j] = rgn_base[t][j + 1];
         rgn_size[t][j] = rgn_size[t][j + 1];
      end
      rgn_count[t]--;
   endfunction

   // Fill the gaps the range covers, then merge touching neighbors
   function automatic brta_pkg::status_type rgn_add(int t, logic [63:0] base,
                                                    logic [63:0] size);
      logic [63:0] lim, b, rb, re;
      int need, i;
      need = 0;
      if (size == 0) return brta_pkg::ST_OK;
      lim = sat_end(base, size);
      if (lim <= base) return brta_pkg::ST_OK;
      b = base;
      for (i = 0; i < rgn_count[t]; i++) begin
         rb = rgn_base[t][i];
         re = rb + rgn_size[t][i];
         if (lim <= rb) break;
         if (b >= re) continue;
         if (b < rb) need++;
         b = (lim < re) ? lim : re;
      end
      if (lim > b) need++;
      if (need > capacity(t) - rgn_count[t]) return brta_pkg::ST_OVERFLOW;
      b = base;
      for (i = 0; i < rgn_count[t]; i++) begin
         rb = rgn_base[t][i];
         re = rb + rgn_size[t][i];
         if (lim <= rb) break;
         if (b >= re) continue;
         if (b < rb) begin
            rgn_insert(t, i, b, rb - b);
            i++;
         end
         b = (lim < re) ? lim : re;
      end
      if (lim > b) rgn_insert(t, i, b, lim - b);
      i = 0;
      while (i + 1 < rgn_count[t]) begin
         if (rgn_base[t][i] + rgn_size[t][i] == rgn_base[t][i + 1]) begin
            rgn_size[t][i] += rgn_size[t][i + 1];
            rgn_delete(t, i + 1);
         end else begin
            i++;
         end
      end
      return brta_pkg::ST_OK;
   endfunction

   // Carve a range out of the first reserved region that holds it
   function automatic brta_pkg::status_type rsv_release(logic [63:0] base,
                                                        logic [63:0] size);
      logic [63:0] lim, rb, re;
      int i;
      rb = 0;
      re = 0;
      if (size == 0) return brta_pkg::ST_OK;
      lim = sat_end(base, size);
      if (lim <= base) return brta_pkg::ST_OK;
      for (i = 0; i < rgn_count[RSV_TBL]; i++) begin
         rb = rgn_base[RSV_TBL][i];
         re = rb + rgn_size[RSV_TBL][i];
         if (base >= rb && lim <= re) break;
      end
      if (i == rgn_count[RSV_TBL]) return brta_pkg::ST_NOT_FOUND;
      if (base == rb) begin
         if (lim == re) begin
            rgn_delete(RSV_TBL, i);
         end else begin
            rgn_base[RSV_TBL][i] = lim;
            rgn_size[RSV_TBL][i] = re - lim;
         end
         return brta_pkg::ST_OK;
      end
      if (lim == re) begin
         rgn_size[RSV_TBL][i] = base - rb;
         return brta_pkg::ST_OK;
      end
      if (rgn_count[RSV_TBL] >= RES_REGIONS) return brta_pkg::ST_OVERFLOW;
      rgn_insert(RSV_TBL, i + 1, lim, re - lim);
      rgn_size[RSV_TBL][i] = base - rb;
      return brta_pkg::ST_OK;
   endfunction

   // First fit over memory minus reserved, aligned up, then reserve the hit
   function automatic brta_pkg::status_type first_fit(logic [63:0] size,
                                                      logic [63:0] minad,
                                                      logic [5:0] lg,
                                                      output logic [63:0] addr);
      logic [63:0] mask, ms, me, gs, ge, fs, fe, a;
      brta_pkg::status_type st;
      mask = (64'd1 << lg) - 64'd1;
      addr = 0;
      for (int m = 0; m < rgn_count[MEM_TBL]; m++) begin
         ms = rgn_base[MEM_TBL][m];
         me = ms + rgn_size[MEM_TBL][m];
         for (int k = 0; k <= rgn_count[RSV_TBL]; k++) begin
            gs = (k == 0) ? 64'd0 : rgn_base[RSV_TBL][k - 1] + rgn_size[RSV_TBL][k - 1];
            ge = (k < rgn_count[RSV_TBL]) ? rgn_base[RSV_TBL][k] : brta_pkg::ALL_ONES;
            if (gs >= me) break;
            if (ms >= ge) continue;
            fs = (ms > gs) ? ms : gs;
            fe = (me < ge) ? me : ge;
            if (fs < minad) continue;
            if (fs > brta_pkg::ALL_ONES - mask) continue;
            a = (fs + mask) & ~mask;
            if (size > brta_pkg::ALL_ONES - a) continue;
            if (a + size > fe) continue;
            st = rgn_add(RSV_TBL, a, size);
            if (st != brta_pkg::ST_OK) return st;
            addr = a;
            return brta_pkg::ST_OK;
         end
      end
      return brta_pkg::ST_NO_FIT;
   endfunction

   function automatic outcome_type apply_request(brta_pkg::mode_type mode,
                                                 logic [199:0] d);
      outcome_type o;
      logic [63:0] addr;
      addr = 0;
      case (mode)
         brta_pkg::MODE_ADD_MEM: o.status = rgn_add(MEM_TBL, d[63:0], d[127:64]);
         brta_pkg::MODE_RESERVE: o.status = rgn_add(RSV_TBL, d[63:0], d[127:64]);
         brta_pkg::MODE_FREE:    o.status = rsv_release(d[63:0], d[127:64]);
         default: o.status = first_fit(d[127:64], d[191:128], d[197:192], addr);
      endcase
      o.alloc_address  = (o.status == brta_pkg::ST_OK) ? addr : 64'd0;
      o.ram_base       = rgn_count[MEM_TBL] ? rgn_base[MEM_TBL][0] : 64'd0;
      o.memory_count   = 8'(rgn_count[MEM_TBL]);
      o.reserved_count = 8'(rgn_count[RSV_TBL]);
      return o;
   endfunction

   assign pending = outcome_q.size();

   // Results are checked before the request of the same edge is applied
   always @(posedge clock) begin
      outcome_type o;
      if (reset) begin
         rgn_count[MEM_TBL] = 0;
         rgn_count[RSV_TBL] = 0;
         outcome_q.delete();
         errors = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (outcome_q.size() == 0) begin
               $error("result transaction with no request outstanding");
               errors++;
            end else begin
               o = outcome_q.pop_front();
               if (rsp_tuser !== o.status) begin
                  $error("status: expected %0d, got %0d", o.status, rsp_tuser);
                  errors++;
               end
               if (rsp_tdata[63:0] !== o.alloc_address) begin
                  $error("alloc_address: expected %h, got %h", o.alloc_address,
                         rsp_tdata[63:0]);
                  errors++;
               end
               if (rsp_tdata[127:64] !== o.ram_base) begin
                  $error("ram_base: expected %h, got %h", o.ram_base, rsp_tdata[127:64]);
                  errors++;
               end
               if (rsp_tdata[135:128] !== o.memory_count) begin
                  $error("memory_count: expected %0d, got %0d", o.memory_count,
                         rsp_tdata[135:128]);
                  errors++;
               end
               if (rsp_tdata[143:136] !== o.reserved_count) begin
                  $error("reserved_count: expected %0d, got %0d", o.reserved_count,
                         rsp_tdata[143:136]);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready)
            outcome_q.push_back(apply_request(brta_pkg::mode_type'(req_tuser), req_tdata));
      end
   end

endmodule

@@ sim/boot_region_table_allocator_core_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the boot region table allocator: stimulus, stalls and verdict.
module boot_region_table_allocator_core_tb;

   localparam logic [63:0] PAGE      = 64'h1000;
   localparam logic [63:0] POOL      = 64'h1_0000_0000;
   localparam logic [63:0] RSV_FILL  = 64'h2_0000_0000;
   localparam logic [63:0] MEM_FILL  = 64'h3_0000_0000;
   localparam logic [63:0] TOP       = brta_pkg::ALL_ONES;
   localparam int          IDLE_MAX  = 20000;
   localparam int          HOLD_LEN  = 2000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [199:0] req_tdata = '0;
   logic [1:0]   req_tuser = brta_pkg::MODE_ADD_MEM;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [143:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   int           errors;
   int           pending;

   int           quiet = 0;
   int           hold_rsp = 0;
   int           hold_left = 0;
   int           stall_left = 0;
   int           idle_cycles = 0;
   logic [127:0] reserved_q[$];

   always #5 clock = ~clock;

   boot_region_table_allocator_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   boot_region_table_allocator_checker chk (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .errors(errors), .pending(pending)
   );

   // Receiver: random stall bursts, one long hold on request
   always @(posedge clock) begin
      if (hold_rsp != 0) begin
         hold_left = HOLD_LEN;
         hold_rsp  = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (quiet == 0 && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 6);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_MAX) begin
         $display("boot_region_table_allocator_core_tb NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // One request transaction, with an optional idle burst ahead of it
   task automatic send(brta_pkg::mode_type mode, logic [63:0] base, logic [63:0] size,
                       logic [63:0] minad, logic [5:0] lg);
      if (quiet == 0 && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {2'b00, lg, minad, size, base};
      if (mode == brta_pkg::MODE_RESERVE) reserved_q.push_back({base, size});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Random operation mix over a small address pool, some full-width noise
   task automatic random_op();
      int          pick;
      logic [63:0] b, s, m;
      logic [127:0] r;
      pick = $urandom_range(0, 99);
      b = POOL + PAGE * $urandom_range(0, 300);
      s = PAGE * $urandom_range(1, 8);
      if ($urandom_range(0, 15) == 0) b = rand64();
      if ($urandom_range(0, 15) == 0) s = rand64();
      if ($urandom_range(0, 31) == 0) b = TOP - PAGE * $urandom_range(0, 3);
      if (pick < 20) begin
         send(brta_pkg::MODE_ADD_MEM, b, s, rand64(), 6'($urandom));
      end else if (pick < 45) begin
         send(brta_pkg::MODE_RESERVE, b, s, rand64(), 6'($urandom));
      end else if (pick < 70) begin
         if (reserved_q.size() != 0 && $urandom_range(0, 3) != 0) begin
            r = reserved_q[$urandom_range(0, reserved_q.size() - 1)];
            b = r[127:64];
            s = r[63:0];
            // whole, head, tail or middle of an earlier reservation
            case ($urandom_range(0, 3))
               0: ;
               1: s = s >> 1;
               2: begin b = b + (s >> 1); s = s - (s >> 1); end
               default: begin b = b + (s >> 2); s = s >> 1; end
            endcase
         end
         send(brta_pkg::MODE_FREE, b, s, rand64(), 6'($urandom));
      end else begin
         s = PAGE * $urandom_range(0, 4) + $urandom_range(0, 2) * 64'h10;
         m = ($urandom_range(0, 1) == 0) ? 64'd0 : POOL + PAGE * $urandom_range(0, 300);
         if ($urandom_range(0, 15) == 0) m = rand64();
         if ($urandom_range(0, 15) == 0) s = rand64();
         send(brta_pkg::MODE_ALLOC, rand64(), s, m,
              ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(0, 16)));
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty tables, empty and saturated ranges, merges, splits, fits
      send(brta_pkg::MODE_ALLOC, 64'd0, PAGE, 64'd0, 6'd0);
      send(brta_pkg::MODE_ADD_MEM, POOL, 64'd0, 64'd0, 6'd0);
      send(brta_pkg::MODE_ADD_MEM, TOP, 64'd5, 64'd0, 6'd0);
      send(brta_pkg::MODE_ADD_MEM, TOP - 64'hFFFF, TOP, 64'd0, 6'd0);
      send(brta_pkg::MODE_ADD_MEM, POOL, 64'h10000, 64'd0, 6'd0);
      send(brta_pkg::MODE_ADD_MEM, POOL + 64'h8000, 64'h10000, 64'd0, 6'd0);
      send(brta_pkg::MODE_ADD_MEM, POOL + 64'h20000, 64'h8000, 64'd0, 6'd0);
      send(brta_pkg::MODE_ADD_MEM, POOL + 64'h18000, 64'h8000, 64'd0, 6'd0);
      send(brta_pkg::MODE_ADD_MEM, 64'd0, 64'h100, 64'd0, 6'd0);
      send(brta_pkg::MODE_RESERVE, POOL + 64'h1000, 64'h4000, 64'd0, 6'd0);
      send(brta_pkg::MODE_RESERVE, POOL, 64'h2000, 64'd0, 6'd0);
      send(brta_pkg::MODE_RESERVE, POOL, 64'd0, 64'd0, 6'd0);
      send(brta_pkg::MODE_FREE, POOL + 64'h40000, PAGE, 64'd0, 6'd0);
      send(brta_pkg::MODE_FREE, POOL + 64'h2000, PAGE, 64'd0, 6'd0);
      send(brta_pkg::MODE_FREE, POOL, PAGE, 64'd0, 6'd0);
      send(brta_pkg::MODE_FREE, POOL + 64'h4000, PAGE, 64'd0, 6'd0);
      send(brta_pkg::MODE_FREE, POOL + 64'h1000, PAGE, 64'd0, 6'd0);
      send(brta_pkg::MODE_FREE, POOL, 64'd0, 64'd0, 6'd0);
      send(brta_pkg::MODE_ALLOC, 64'd0, 64'h100, 64'd0, 6'd12);
      send(brta_pkg::MODE_ALLOC, 64'd0, 64'h100, POOL + 64'h10, 6'd4);
      send(brta_pkg::MODE_ALLOC, 64'd0, 64'd0, 64'd0, 6'd0);
      send(brta_pkg::MODE_ALLOC, 64'd0, PAGE, 64'd0, 6'd63);
      send(brta_pkg::MODE_ALLOC, 64'd0, TOP, 64'd0, 6'd0);
      send(brta_pkg::MODE_ALLOC, 64'd0, PAGE, TOP, 6'd0);

      for (int i = 0; i < 340; i++) random_op();

      // Fragment memory past table capacity
      for (int i = 0; i < 135; i++)
         send(brta_pkg::MODE_ADD_MEM, MEM_FILL + PAGE * 2 * i, PAGE, 64'd0, 6'd0);

      // Long receiver hold while requests keep coming
      hold_rsp = 1;
      for (int i = 0; i < 200; i++) random_op();

      // Fragment reserved past table capacity, then give most of it back
      for (int i = 0; i < 135; i++)
         send(brta_pkg::MODE_RESERVE, RSV_FILL + PAGE * 2 * i, PAGE, 64'd0, 6'd0);
      send(brta_pkg::MODE_FREE, RSV_FILL + 64'h800, 64'h100, 64'd0, 6'd0);
      for (int i = 0; i < 100; i++)
         send(brta_pkg::MODE_FREE, RSV_FILL + PAGE * 2 * i, PAGE, 64'd0, 6'd0);

      // Final stretch with no idling on either side
      quiet = 1;
      for (int i = 0; i < 230; i++) random_op();
      req_tvalid <= 1'b0;

      // let the checker record the last request before draining
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("boot_region_table_allocator_core_tb OK");
      end else begin
         $display("boot_region_table_allocator_core_tb NOT OK");
      end
      $finish;
   end

endmodule
